/* hw/rtl/mcc_pkg.sv */
// shared types, constants and codes of the morse code table codec
// no dependencies; compile first
`default_nettype none

package mcc_pkg;

    // table depth default, used as the default of the top level parameter
    localparam int TABLE_ENTRIES_DEF = 26;

    // code format, fixed by the field widths
    localparam int MAX_SYMBOLS = 4;
    localparam int LEN_W       = 3;
    localparam int PAT_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 5;
    localparam int ACTION_W    = 2;
    localparam int KIND_W      = 2;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_DASH     = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_DOT      = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'd97;
    localparam logic [CHAR_W-1:0] ALPHABET      = 8'd26;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SYMBOLS);

    // request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_DECODE = 2'd2
    } action_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        RES_CODE   = 2'd0,
        RES_STOP   = 2'd1,
        RES_LETTER = 2'd2
    } kind_t;

    // operation carried down the cell chain
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_CODE  = 3'd2,
        OP_STOP  = 3'd3,
        OP_MATCH = 3'd4
    } op_t;

    // payload of one request
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_in;
        logic                last_char;
        logic [IDX_W-1:0]    entry_index;
        logic [CHAR_W-1:0]   entry_letter;
        logic [LEN_W-1:0]    entry_length;
        logic [PAT_W-1:0]    entry_pattern;
    } req_t;

    // item handed from cell to cell
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [CHAR_W-1:0] letter;
        logic [LEN_W-1:0]  length;
        logic [PAT_W-1:0]  pattern;
        logic              found;
    } item_t;

endpackage

`default_nettype wire

/* hw/rtl/mcc_if.sv */
// request and result channel interfaces of the morse code table codec
// depends on mcc_pkg
`default_nettype none

interface mcc_req_if;
    import mcc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_in;
    logic                last_char;
    logic [IDX_W-1:0]    entry_index;
    logic [CHAR_W-1:0]   entry_letter;
    logic [LEN_W-1:0]    entry_length;
    logic [PAT_W-1:0]    entry_pattern;

    modport source (
        output valid, action, char_in, last_char, entry_index, entry_letter,
               entry_length, entry_pattern,
        input  ready
    );

    modport sink (
        input  valid, action, char_in, last_char, entry_index, entry_letter,
               entry_length, entry_pattern,
        output ready
    );
endinterface

interface mcc_res_if;
    import mcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [LEN_W-1:0]  code_length;
    logic [PAT_W-1:0]  code_pattern;
    logic [CHAR_W-1:0] letter_out;

    modport source (
        output valid, result_kind, code_length, code_pattern, letter_out,
        input  ready
    );

    modport sink (
        input  valid, result_kind, code_length, code_pattern, letter_out,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/mcc_front.sv */
// front end: request decode and decode-token gathering, builds the chain item
// depends on mcc_pkg
`default_nettype none

module mcc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire mcc_pkg::req_t  req,
    output mcc_pkg::item_t      item
);
    import mcc_pkg::*;

    logic [PAT_W-1:0] tok_pat_reg, tok_pat_next;
    logic [LEN_W-1:0] tok_len_reg, tok_len_next;
    logic             tok_bad_reg, tok_bad_next;

    logic [CHAR_W-1:0] ch;
    logic              is_upper;
    logic              is_lower;
    logic [CHAR_W-1:0] pos;
    logic [LEN_W-1:0]  load_len;
    logic [PAT_W:0]    load_mask;
    logic              is_sep;
    logic              is_sym;
    logic [PAT_W-1:0]  new_pat;
    logic [LEN_W-1:0]  new_len;
    logic              new_bad;
    logic              do_flush;
    logic [PAT_W-1:0]  fl_pat;
    logic [LEN_W-1:0]  fl_len;
    logic              fl_bad;

    assign ch = req.char_in;

    // letter classification for encode
    assign is_upper = (ch >= CHAR_UPPER_A) && (ch < CHAR_UPPER_A + ALPHABET);
    assign is_lower = (ch >= CHAR_LOWER_A) && (ch < CHAR_LOWER_A + ALPHABET);
    assign pos      = is_upper ? (ch - CHAR_UPPER_A) : (ch - CHAR_LOWER_A);

    // load: saturate length, clear pattern bits past the length
    assign load_len  = (req.entry_length > MAX_LEN) ? MAX_LEN : req.entry_length;
    assign load_mask = ((PAT_W+1)'(1) << load_len) - (PAT_W+1)'(1);

    // decode symbol step on the current token
    assign is_sep = (ch == CHAR_SPACE) || (ch == CHAR_NUL);
    assign is_sym = (ch == CHAR_DOT) || (ch == CHAR_DASH);

    always_comb
    begin
        new_pat = tok_pat_reg;
        new_len = tok_len_reg;
        new_bad = tok_bad_reg;
        if (is_sym && (tok_len_reg < MAX_LEN))
        begin
            if (ch == CHAR_DASH)
            begin
                new_pat = tok_pat_reg | (PAT_W'(1) << tok_len_reg);
            end
            new_len = tok_len_reg + LEN_W'(1);
        end
        else
        begin
            new_bad = 1'b1;
        end
    end

    // build the item and the next token state
    always_comb
    begin
        item         = '0;
        item.op      = OP_NONE;
        tok_pat_next = tok_pat_reg;
        tok_len_next = tok_len_reg;
        tok_bad_next = tok_bad_reg;
        do_flush     = 1'b0;
        fl_pat       = tok_pat_reg;
        fl_len       = tok_len_reg;
        fl_bad       = tok_bad_reg;
        case (action_t'(req.action))
            ACT_LOAD:
            begin
                item.op      = OP_LOAD;
                item.idx     = req.entry_index;
                item.letter  = req.entry_letter;
                item.length  = load_len;
                item.pattern = req.entry_pattern & load_mask[PAT_W-1:0];
            end
            ACT_ENCODE:
            begin
                item.op  = (is_upper || is_lower) ? OP_CODE : OP_STOP;
                item.idx = (is_upper || is_lower) ? pos[IDX_W-1:0] : '0;
            end
            ACT_DECODE:
            begin
                if (is_sep)
                begin
                    do_flush = 1'b1;
                end
                else
                begin
                    fl_pat   = new_pat;
                    fl_len   = new_len;
                    fl_bad   = new_bad;
                    do_flush = req.last_char;
                end
                if (do_flush)
                begin
                    item.op      = fl_bad ? OP_NONE : OP_MATCH;
                    item.length  = fl_len;
                    item.pattern = fl_pat;
                    tok_pat_next = '0;
                    tok_len_next = '0;
                    tok_bad_next = 1'b0;
                end
                else
                begin
                    tok_pat_next = new_pat;
                    tok_len_next = new_len;
                    tok_bad_next = new_bad;
                end
            end
            default:
            begin
                item.op = OP_NONE;
            end
        endcase
    end

    // token registers advance only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_pat_reg <= '0;
            tok_len_reg <= '0;
            tok_bad_reg <= 1'b0;
        end
        else if (take)
        begin
            tok_pat_reg <= tok_pat_next;
            tok_len_reg <= tok_len_next;
            tok_bad_reg <= tok_bad_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mcc_cell.sv */
// one chain cell: holds one table entry and one pipeline stage of the item flow
// depends on mcc_pkg
`default_nettype none

module mcc_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           valid_in,
    input  wire mcc_pkg::item_t item_in,
    output logic                valid_out,
    output mcc_pkg::item_t      item_out
);
    import mcc_pkg::*;

    logic [CHAR_W-1:0] letter_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [PAT_W-1:0]  pattern_reg;
    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic              hit;

    assign hit = (32'(item_in.idx) == CELL_ID);

    // apply this cell's entry to the passing item
    always_comb
    begin
        item_next = item_in;
        case (item_in.op)
            OP_CODE:
            begin
                if (hit)
                begin
                    item_next.length  = length_reg;
                    item_next.pattern = pattern_reg;
                end
            end
            OP_MATCH:
            begin
                if (!item_in.found && (item_in.length == length_reg)
                    && (item_in.pattern == pattern_reg))
                begin
                    item_next.found  = 1'b1;
                    item_next.letter = letter_reg + LETTER_OFFSET;
                end
            end
            default:
            begin
                item_next = item_in;
            end
        endcase
    end

    // table entry, written by a passing load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_reg  <= '0;
            length_reg  <= '0;
            pattern_reg <= '0;
        end
        else if (advance && valid_in && (item_in.op == OP_LOAD) && hit)
        begin
            letter_reg  <= item_in.letter;
            length_reg  <= item_in.length;
            pattern_reg <= item_in.pattern;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

`default_nettype wire

/* hw/rtl/morse_code_table_codec.sv */
// Morse code table codec, top level: front end plus a chain of table cells
// depends on mcc_pkg, mcc_if, mcc_front, mcc_cell
//
// Usage:
//   request channel: action 0 loads one table entry, 1 encodes a character,
//   2 feeds one character of a dot/dash string to the decoder. A request is
//   taken when valid and ready are high at a rising edge of clk.
//   result channel: one result per encode, one per decode token that ends
//   and matches a table entry; loads and other decode characters give none.
//   Each request walks the cell chain, one cell per cycle while the chain
//   is not held, each cell owning one table entry; the last cell registers
//   the result. Throughput: one request per cycle while the chain is not held.
//   Stall: the last cell is the output register. While it holds a result
//   that is not taken, the whole chain holds and ready is low; requests with
//   no result never block the output.
//   Reset (rst_n low, asynchronous): table entries clear to empty codes and
//   zero letters, the partial decode token clears, the chain empties.
`default_nettype none

module morse_code_table_codec #(
    parameter int TABLE_ENTRIES = mcc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mcc_req_if.sink   request,
    mcc_res_if.source result
);
    import mcc_pkg::*;

    logic  advance;
    req_t  req;
    logic  chain_valid [TABLE_ENTRIES+1];
    item_t chain_item  [TABLE_ENTRIES+1];
    item_t last_item;
    logic  last_has_result;

    // whole chain moves unless a finished result is stalled
    assign advance       = !result.valid || result.ready;
    assign request.ready = advance;

    // request payload
    assign req.action        = request.action;
    assign req.char_in       = request.char_in;
    assign req.last_char     = request.last_char;
    assign req.entry_index   = request.entry_index;
    assign req.entry_letter  = request.entry_letter;
    assign req.entry_length  = request.entry_length;
    assign req.entry_pattern = request.entry_pattern;

    mcc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (request.valid && advance),
        .req   (req),
        .item  (chain_item[0])
    );

    assign chain_valid[0] = request.valid;

    // cell chain, one cell per table entry
    for (genvar k = 0; k < TABLE_ENTRIES; k++)
    begin : g_cell
        mcc_cell #(
            .CELL_ID (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (chain_valid[k]),
            .item_in   (chain_item[k]),
            .valid_out (chain_valid[k+1]),
            .item_out  (chain_item[k+1])
        );
    end

    // result formatting from the last cell
    assign last_item       = chain_item[TABLE_ENTRIES];
    assign last_has_result = (last_item.op == OP_CODE) || (last_item.op == OP_STOP)
                             || ((last_item.op == OP_MATCH) && last_item.found);

    assign result.valid = chain_valid[TABLE_ENTRIES] && last_has_result;

    always_comb
    begin
        result.result_kind  = RES_STOP;
        result.code_length  = '0;
        result.code_pattern = '0;
        result.letter_out   = '0;
        case (last_item.op)
            OP_CODE:
            begin
                result.result_kind  = RES_CODE;
                result.code_length  = last_item.length;
                result.code_pattern = last_item.pattern;
            end
            OP_MATCH:
            begin
                result.result_kind = RES_LETTER;
                result.letter_out  = last_item.letter;
            end
            default:
            begin
                result.result_kind = RES_STOP;
            end
        endcase
    end

    // only encode results carry a code
    a_code_only_on_encode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.result_kind != RES_CODE))
        |-> ((result.code_length == '0) && (result.code_pattern == '0)))
        else $error("code fields set on a non-code result");

    // only decode results carry a letter
    a_letter_only_on_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.result_kind != RES_LETTER))
        |-> (result.letter_out == '0))
        else $error("letter set on a non-letter result");

    // a new result appears only when the chain moved
    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(advance))
        else $error("result appeared while the chain was held");

endmodule

`default_nettype wire

/* test/morse_code_table_codec_checker.sv */
// result checker for the morse code table codec: watches both channels,
// keeps its own copy of the table and token, and compares every result
// depends on mcc_pkg and mcc_if
`timescale 1ns / 100ps

module morse_code_table_codec_checker #(
    parameter int TABLE_ENTRIES = mcc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mcc_req_if        request,
    mcc_res_if        result,
    output int        failures,
    output int        outstanding
);
    import mcc_pkg::*;

    // one result as it should appear on the result channel
    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  length;
        logic [PAT_W-1:0]  pattern;
        logic [CHAR_W-1:0] letter;
    } codec_result_t;

    // shadow table and partial decode token
    logic [CHAR_W-1:0] entry_letters  [TABLE_ENTRIES];
    logic [LEN_W-1:0]  entry_lengths  [TABLE_ENTRIES];
    logic [PAT_W-1:0]  entry_patterns [TABLE_ENTRIES];
    logic [PAT_W-1:0]  token_symbols;
    logic [LEN_W-1:0]  token_count;
    logic              token_broken;

    codec_result_t     awaited_results [$];
    int                mismatch_total = 0;

    // end the token: first entry with the same code wins, a broken token matches nothing
    task automatic close_token(output logic hit, output codec_result_t res);
        int k;
        hit = 1'b0;
        res = '0;
        if (!token_broken)
        begin
            for (k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (!hit && entry_lengths[k] == token_count &&
                    entry_patterns[k] == token_symbols)
                begin
                    hit        = 1'b1;
                    res.kind   = RES_LETTER;
                    res.letter = entry_letters[k] + LETTER_OFFSET;
                end
            end
        end
        token_symbols = '0;
        token_count   = '0;
        token_broken  = 1'b0;
    endtask

    // work out the effect of one accepted request and the result it gives, if any
    task automatic translate_request(output logic hit, output codec_result_t res);
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] ch;
        int                pos;
        ch  = request.char_in;
        hit = 1'b0;
        res = '0;
        case (request.action)
            ACT_LOAD:
            begin
                // out of range index is dropped, long codes saturate, slack bits clear
                if (request.entry_index < TABLE_ENTRIES)
                begin
                    len = (request.entry_length > MAX_LEN) ? MAX_LEN : request.entry_length;
                    entry_letters[request.entry_index]  = request.entry_letter;
                    entry_lengths[request.entry_index]  = len;
                    entry_patterns[request.entry_index] =
                        request.entry_pattern & PAT_W'((1 << len) - 1);
                end
            end
            ACT_ENCODE:
            begin
                hit = 1'b1;
                if (ch >= CHAR_UPPER_A && ch < CHAR_UPPER_A + ALPHABET)
                    pos = int'(ch - CHAR_UPPER_A);
                else if (ch >= CHAR_LOWER_A && ch < CHAR_LOWER_A + ALPHABET)
                    pos = int'(ch - CHAR_LOWER_A);
                else
                    pos = -1;
                if (pos < 0)
                    res.kind = RES_STOP;
                else if (pos < TABLE_ENTRIES)
                begin
                    res.kind    = RES_CODE;
                    res.length  = entry_lengths[pos];
                    res.pattern = entry_patterns[pos];
                end
                else
                    res.kind = RES_CODE;
            end
            ACT_DECODE:
            begin
                if (ch == CHAR_SPACE || ch == CHAR_NUL)
                    close_token(hit, res);
                else
                begin
                    // symbols beyond the limit and foreign bytes spoil the token
                    if ((ch == CHAR_DOT || ch == CHAR_DASH) && token_count < MAX_LEN)
                    begin
                        if (ch == CHAR_DASH)
                            token_symbols = token_symbols | PAT_W'(1 << token_count);
                        token_count = token_count + 1'b1;
                    end
                    else
                        token_broken = 1'b1;
                    if (request.last_char)
                        close_token(hit, res);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    // results first, then the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        codec_result_t want;
        codec_result_t fresh;
        logic          fresh_hit;
        int            k;
        if (!rst_n)
        begin
            for (k = 0; k < TABLE_ENTRIES; k++)
            begin
                entry_letters[k]  = '0;
                entry_lengths[k]  = '0;
                entry_patterns[k] = '0;
            end
            token_symbols = '0;
            token_count   = '0;
            token_broken  = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result_kind: expected no result, actual %0d", result.result_kind);
                    mismatch_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", want.kind, result.result_kind);
                    check_field("code_length", want.length, result.code_length);
                    check_field("code_pattern", want.pattern, result.code_pattern);
                    check_field("letter_out", want.letter, result.letter_out);
                end
            end
            if (request.valid && request.ready)
            begin
                translate_request(fresh_hit, fresh);
                if (fresh_hit)
                    awaited_results.push_back(fresh);
            end
        end
        failures    <= mismatch_total;
        outstanding <= awaited_results.size();
    end

endmodule

/* test/morse_code_table_codec_tb.sv */
// top of the morse code table codec testbench: clock, reset, request and result
// traffic with random idling, and the verdict
// depends on mcc_pkg, mcc_if, morse_code_table_codec and its checker
`timescale 1ns / 100ps

module morse_code_table_codec_tb;
    import mcc_pkg::*;

    localparam int                  TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int                  RANDOM_ITEMS  = 1050;
    localparam int                  CALM_TAIL     = 150;
    localparam int                  LONG_HOLD     = 160;
    localparam int                  SETTLE_CYCLES = 3 * TABLE_ENTRIES;
    localparam int                  CYCLE_LIMIT   = 200000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED    = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mcc_req_if request ();
    mcc_res_if result ();

    int failures;
    int outstanding;
    int cycle_count     = 0;
    int items_sent      = 0;
    bit idling_on       = 1'b1;
    bit long_hold_armed = 1'b0;

    morse_code_table_codec #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .result (result)
    );

    morse_code_table_codec_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) codec_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .result     (result),
        .failures   (failures),
        .outstanding(outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("morse_code_table_codec verification failed");
            $finish;
        end
    end

    // all fields random, callers overwrite the ones that matter
    function automatic req_t random_request();
        req_t r;
        r.action        = ACTION_W'($urandom);
        r.char_in       = CHAR_W'($urandom);
        r.last_char     = 1'($urandom);
        r.entry_index   = IDX_W'($urandom);
        r.entry_letter  = CHAR_W'($urandom);
        r.entry_length  = LEN_W'($urandom);
        r.entry_pattern = PAT_W'($urandom);
        return r;
    endfunction

    // offer one request, maybe after a short gap, and wait until it is taken
    task automatic push_request(input req_t r);
        int span;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            span = $urandom_range(1, 6);
            request.valid <= 1'b0;
            repeat (span) @(posedge clk);
        end
        request.valid         <= 1'b1;
        request.action        <= r.action;
        request.char_in       <= r.char_in;
        request.last_char     <= r.last_char;
        request.entry_index   <= r.entry_index;
        request.entry_letter  <= r.entry_letter;
        request.entry_length  <= r.entry_length;
        request.entry_pattern <= r.entry_pattern;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        if (!(r.action == ACT_UNUSED ||
              (r.action == ACT_LOAD && r.entry_index >= TABLE_ENTRIES)))
            items_sent++;
    endtask

    task automatic send_load(input int idx, input logic [CHAR_W-1:0] letter,
                             input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat);
        req_t r;
        r               = random_request();
        r.action        = ACT_LOAD;
        r.entry_index   = IDX_W'(idx);
        r.entry_letter  = letter;
        r.entry_length  = len;
        r.entry_pattern = pat;
        push_request(r);
    endtask

    task automatic send_encode(input logic [CHAR_W-1:0] ch);
        req_t r;
        r         = random_request();
        r.action  = ACT_ENCODE;
        r.char_in = ch;
        push_request(r);
    endtask

    task automatic send_decode(input logic [CHAR_W-1:0] ch, input logic last);
        req_t r;
        r           = random_request();
        r.action    = ACT_DECODE;
        r.char_in   = ch;
        r.last_char = last;
        push_request(r);
    endtask

    task automatic send_unused();
        req_t r;
        r        = random_request();
        r.action = ACT_UNUSED;
        push_request(r);
    endtask

    // decode a string, optionally marking its final character as the last one
    task automatic send_text(input string s, input logic mark_last);
        int k;
        for (k = 0; k < s.len(); k++)
            send_decode(s[k], mark_last && k == s.len() - 1);
    endtask

    // one dot/dash token, mostly well formed, ended by space, NUL or the last flag
    task automatic send_token();
        int                span;
        int                ending;
        int                k;
        logic [CHAR_W-1:0] sym;
        span   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, MAX_SYMBOLS)
                                             : $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 2);
        ending = $urandom_range(0, 2);
        for (k = 0; k < span; k++)
        begin
            sym = $urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT;
            if ($urandom_range(0, 24) == 0)
                sym = CHAR_W'($urandom);
            send_decode(sym, ending == 2 && k == span - 1);
        end
        if (ending != 2 || span == 0)
            send_decode(ending == 1 ? CHAR_NUL : CHAR_SPACE, 1'($urandom));
    endtask

    // result side: random hold-offs, one long hold once armed
    initial
    begin : result_sink
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        result.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_armed && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                result.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                span = $urandom_range(1, 6);
                result.ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // request side and verdict
    initial
    begin : stimulus
        int goal;
        int next_shuffle;
        int n;
        int pick;
        request.valid         <= 1'b0;
        request.action        <= ACT_LOAD;
        request.char_in       <= '0;
        request.last_char     <= 1'b0;
        request.entry_index   <= '0;
        request.entry_letter  <= '0;
        request.entry_length  <= '0;
        request.entry_pattern <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: empty code, and an empty token matches the first entry
        send_encode(CHAR_UPPER_A);
        send_text(" ", 1'b0);

        // loads with slack bits, saturating length and an index past the table
        send_load(0, CHAR_UPPER_A, 3'd2, 4'b1110);
        send_load(TABLE_ENTRIES - 1, 8'hFF, 3'd7, 4'hF);
        send_load(31, 8'h55, 3'd3, 4'h5);
        send_load(4, 8'h45, 3'd1, 4'h0);

        // letter edges and non-letters
        send_encode(CHAR_LOWER_A);
        send_encode(CHAR_UPPER_A + ALPHABET - 8'd1);
        send_encode(CHAR_LOWER_A + ALPHABET - 8'd1);
        send_encode(CHAR_UPPER_A - 8'd1);
        send_encode(CHAR_LOWER_A + ALPHABET);
        send_encode(CHAR_NUL);
        send_encode(8'hFF);
        send_unused();

        // decode: match, letter wraparound, overlong token, foreign character
        send_text(".-", 1'b1);
        send_text("----", 1'b1);
        send_text(".....", 1'b1);
        send_text("x", 1'b1);

        // random part on a fully loaded table
        for (n = 0; n < TABLE_ENTRIES; n++)
            send_load(n, CHAR_W'($urandom), LEN_W'($urandom), PAT_W'($urandom));
        goal         = items_sent + RANDOM_ITEMS;
        next_shuffle = items_sent + 100;
        while (items_sent < goal)
        begin
            if (items_sent >= goal - CALM_TAIL)
                idling_on = 1'b0;
            else if (items_sent >= next_shuffle)
            begin
                idling_on    = ($urandom_range(0, 3) != 0);
                next_shuffle = items_sent + 100;
            end

            // long receiver hold while encodes keep coming, so the chain backs up
            if (!long_hold_armed && items_sent >= goal - 2 * RANDOM_ITEMS / 3)
            begin
                long_hold_armed = 1'b1;
                repeat (80) send_encode(CHAR_W'($urandom));
            end

            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_token();
            else if (pick < 64)
                send_encode(CHAR_UPPER_A + CHAR_W'($urandom_range(0, ALPHABET - 1)));
            else if (pick < 78)
                send_encode(CHAR_LOWER_A + CHAR_W'($urandom_range(0, ALPHABET - 1)));
            else if (pick < 86)
                send_encode(CHAR_W'($urandom));
            else if (pick < 92)
                send_load($urandom_range(0, 31), CHAR_W'($urandom), LEN_W'($urandom),
                          PAT_W'($urandom));
            else if (pick < 97)
                send_decode(CHAR_W'($urandom), 1'($urandom));
            else
                send_unused();
        end
        request.valid <= 1'b0;

        // drain, then let the chain empty out
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("morse_code_table_codec verification clean");
        else
            $display("morse_code_table_codec verification failed");
        $finish;
    end

endmodule
